// ===== src/dqpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dqpc_pkg: shared types and constants
// Constants, cell control type and tree depth helper for the DNA q-gram
// pattern counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dqpc_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int GRAM_SIZE = 4;
	localparam logic [7:0] FP_MASK = 8'h06;
	localparam int TREE_FANIN = 8;

	typedef struct packed {
		logic pat_shift;
		logic txt_shift;
	} cell_ctl_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic len_nz;
		logic ovf;
	} side_t;

	function automatic int clog8(input int n);
		int lv;
		int w;
		lv = 0;
		w = 1;
		for (int i = 0; i < 8; i++) begin
			if (w < n) begin
				w = w * TREE_FANIN;
				lv = lv + 1;
			end
		end
		if (lv == 0) begin
			lv = 1;
		end
		return lv;
	endfunction

endpackage

`default_nettype wire

// ===== src/dqpc_cell.sv =====
// ----------------------------------------------------------------------------
// dqpc_cell: one pattern / window position
// Holds one pattern byte and one window byte, shifts both toward the older
// end, and registers whether its position agrees with the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpc_cell
	import dqpc_pkg::*;
#(
	parameter int LEN_W = 7,
	parameter int K = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire logic [LEN_W-1:0] exact_bound,
	input  wire logic [7:0]       pat_in,
	input  wire logic             pv_in,
	input  wire logic [7:0]       win_in,
	input  wire logic             tv_in,
	output logic [7:0]            pat,
	output logic                  pv,
	output logic [7:0]            win,
	output logic                  tv,
	output logic                  ok
);

	localparam logic [LEN_W-1:0] IDX = LEN_W'(K);

	logic [7:0] pat_q;
	logic [7:0] win_q;
	logic       pv_q;
	logic       tv_q;
	logic       ok_s1;
	logic       exact;
	logic       same;

	always_comb begin
		exact = IDX < exact_bound;
		if (exact) begin
			same = pat_q == win_in;
		end else begin
			same = (pat_q & FP_MASK) == (win_in & FP_MASK);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pat_shift) begin
			pat_q <= pat_in;
		end
		if (ctl.txt_shift) begin
			win_q <= win_in;
			ok_s1 <= ~pv_q | (tv_in & same);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			tv_q <= 1'b0;
		end else begin
			if (ctl.pat_shift) begin
				pv_q <= pv_in;
			end
			if (ctl.txt_shift) begin
				tv_q <= tv_in;
			end
		end
	end

	assign pat = pat_q;
	assign pv  = pv_q;
	assign win = win_q;
	assign tv  = tv_q;
	assign ok  = ok_s1;

endmodule

`default_nettype wire

// ===== src/dqpc_and_tree.sv =====
// ----------------------------------------------------------------------------
// dqpc_and_tree: registered AND reduction
// Reduces the per-cell agreement bits eight to one per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpc_and_tree
	import dqpc_pkg::*;
#(
	parameter int WIDTH = 64,
	parameter int LEVELS = 2
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] bits,
	output logic                  all_ones
);

	logic [WIDTH-1:0] lvl_s [1:LEVELS];
	logic [WIDTH-1:0] red [1:LEVELS];

	always_comb begin
		for (int l = 1; l <= LEVELS; l++) begin
			for (int i = 0; i < WIDTH; i++) begin
				red[l][i] = 1'b1;
				for (int b = 0; b < TREE_FANIN; b++) begin
					if (i * TREE_FANIN + b < WIDTH) begin
						if (l == 1) begin
							red[l][i] = red[l][i] & bits[i * TREE_FANIN + b];
						end else begin
							red[l][i] = red[l][i] & lvl_s[l-1][i * TREE_FANIN + b];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 1; l <= LEVELS; l++) begin
				lvl_s[l] <= red[l];
			end
		end
	end

	assign all_ones = lvl_s[LEVELS][0];

endmodule

`default_nettype wire

// ===== src/dna_qgram_pattern_count_top.sv =====
// ----------------------------------------------------------------------------
// dna_qgram_pattern_count_top: DNA q-gram pattern counter
// Loads a pattern byte by byte into a row of cells, streams text through the
// same row and counts windows that match the pattern head exactly and the
// rest by the 2-bit fingerprint.
//
//  channel  dir  word                               result
//  s_axis   in   pattern or text byte               text byte only
//  m_axis   out  match flag, count, overflow flag   one per text byte
//
// One word accepted per cycle while no waiting result stalls it; a text result is registered
// in the cells, the AND tree of depth LEVELS = ceil(log8(MAX_PATTERN)) and the output stage.
// Reset clears pattern length, window fill, count and overflow at once.
// m_axis_tready low while a result word waits freezes the whole row and the
// tree, and s_axis_tready follows it in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dna_qgram_pattern_count_top
	import dqpc_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // data[7:0]
	input  wire logic [1:0]  s_axis_tuser,   // command[0], first[1]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // match_count[31:0]
	output logic [1:0]       m_axis_tuser,   // match_end[0], pattern_overflow[1]
	output logic             m_axis_tlast
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int LEVELS = clog8(MAX_PATTERN);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);
	localparam logic [LEN_W-1:0] GRAM_MASK = LEN_W'(GRAM_SIZE - 1);

	logic             en;
	logic             fire;
	logic             first;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [31:0]      count_q;
	logic             out_valid_q;
	logic             out_hit_q;
	logic             out_last_q;
	logic             out_ovf_q;
	logic [LEN_W-1:0] exact_bound;
	cell_ctl_t        ctl;
	side_t            side_s [0:LEVELS];
	side_t            side_d;
	side_t            side_f;
	logic             hit;
	logic             tree_all;
	logic [31:0]      count_base;
	logic [31:0]      count_nxt;

	logic [7:0] pat_c [MAX_PATTERN];
	logic [7:0] win_c [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] pv_c;
	logic [MAX_PATTERN-1:0] tv_c;
	logic [MAX_PATTERN-1:0] ok_c;

	assign en            = ~out_valid_q | m_axis_tready;
	assign s_axis_tready = en;
	assign fire          = s_axis_tvalid & en;
	assign first         = s_axis_tuser[1];

	assign ctl.pat_shift = fire & ~s_axis_tuser[0] & (first | (len_q != MAX_LEN));
	assign ctl.txt_shift = fire & s_axis_tuser[0];

	assign exact_bound = MAX_LEN - len_q + (len_q & GRAM_MASK);

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [7:0] pat_in;
		logic       pv_in;
		logic [7:0] win_in;
		logic       tv_in;
		if (k == MAX_PATTERN - 1) begin : g_top
			assign pat_in = s_axis_tdata;
			assign pv_in  = 1'b1;
			assign win_in = s_axis_tdata;
			assign tv_in  = 1'b1;
		end else begin : g_mid
			assign pat_in = pat_c[k+1];
			assign pv_in  = pv_c[k+1] & ~first;
			assign win_in = win_c[k+1];
			assign tv_in  = tv_c[k+1] & ~first;
		end
		dqpc_cell #(
			.LEN_W(LEN_W),
			.K(k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.exact_bound(exact_bound),
			.pat_in     (pat_in),
			.pv_in      (pv_in),
			.win_in     (win_in),
			.tv_in      (tv_in),
			.pat        (pat_c[k]),
			.pv         (pv_c[k]),
			.win        (win_c[k]),
			.tv         (tv_c[k]),
			.ok         (ok_c[k])
		);
	end

	dqpc_and_tree #(
		.WIDTH (MAX_PATTERN),
		.LEVELS(LEVELS)
	) u_tree (
		.clk     (clk),
		.en      (en),
		.bits    (ok_c),
		.all_ones(tree_all)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (fire && !s_axis_tuser[0]) begin
			if (first) begin
				len_q <= LEN_W'(1);
				ovf_q <= 1'b0;
			end else if (len_q != MAX_LEN) begin
				len_q <= len_q + LEN_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_comb begin
		side_d.valid  = ctl.txt_shift;
		side_d.first  = first;
		side_d.last   = s_axis_tlast;
		side_d.len_nz = len_q != '0;
		side_d.ovf    = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= LEVELS; l++) begin
				side_s[l] <= '0;
			end
		end else if (en) begin
			side_s[0] <= side_d;
			for (int l = 1; l <= LEVELS; l++) begin
				side_s[l] <= side_s[l-1];
			end
		end
	end

	always_comb begin
		side_f     = side_s[LEVELS];
		hit        = tree_all & side_f.len_nz;
		count_base = side_f.first ? '0 : count_q;
		count_nxt  = count_base;
		if (hit && count_base != '1) begin
			count_nxt = count_base + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			out_hit_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_f.valid;
			if (side_f.valid) begin
				count_q    <= count_nxt;
				out_hit_q  <= hit;
				out_last_q <= side_f.last;
				out_ovf_q  <= side_f.ovf;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = count_q;
	assign m_axis_tuser  = {out_ovf_q, out_hit_q};
	assign m_axis_tlast  = out_last_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= MAX_LEN)
		else $error("pattern length beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == MAX_LEN)
		else $error("overflow flagged with room left");

	a_pv_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pv_c) == int'(len_q))
		else $error("pattern valid bits disagree with length");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata != '0)
		else $error("match reported with zero count");

endmodule

`default_nettype wire

// ===== sim/tb_dna_qgram_pattern_count_top.sv =====
// ----------------------------------------------------------------------------
// tb_dna_qgram_pattern_count_top: self-checking bench for the q-gram counter
// Loads patterns of many lengths, including the full capacity and beyond it,
// and streams text with planted and spoiled occurrences through s_axis.
// Every m_axis word is checked field by field against a cycle-free model
// kept in a small scoreboard. Both sides idle in random bursts; the sink
// also holds off once for a long stretch so the block fills up.
// ----------------------------------------------------------------------------

module tb_dna_qgram_pattern_count_top;
	import dqpc_pkg::*;

	localparam int     PAT_CAP      = MAX_PATTERN_DEF;
	localparam bit     CMD_PATTERN  = 1'b0;
	localparam bit     CMD_TEXT     = 1'b1;
	localparam int     RANDOM_WORDS = 1450;
	localparam int     CALM_WORDS   = 150;
	localparam int     DRAIN_CYCLES = 20;
	localparam int     LONG_HOLD    = 80;
	localparam int     CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic        match_end;
		logic [31:0] match_count;
		logic        final_res;
		logic        pattern_overflow;
	} text_result_t;

	class occurrence_board;
		logic [7:0]   pat_bytes [PAT_CAP];
		logic [7:0]   win_bytes [PAT_CAP];
		int unsigned  pat_len = 0;
		int unsigned  win_fill = 0;
		logic [31:0]  hits = '0;
		logic         ovf = 1'b0;
		text_result_t due[$];
		int unsigned  errors = 0;

		function bit window_hit();
			int unsigned r;
			int unsigned base;
			if (pat_len == 0 || win_fill < pat_len) return 1'b0;
			r = pat_len % GRAM_SIZE;
			base = PAT_CAP - pat_len;
			for (int unsigned j = 0; j < pat_len; j++) begin
				if (j < r) begin
					if (pat_bytes[j] != win_bytes[base + j]) return 1'b0;
				end else if ((pat_bytes[j] & FP_MASK) !=
				             (win_bytes[base + j] & FP_MASK)) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function void take_word(bit cmd, logic [7:0] data, bit first, bit last);
			text_result_t res;
			bit hit;
			if (cmd == CMD_PATTERN) begin
				if (first) begin
					pat_len = 0;
					ovf = 1'b0;
				end
				if (pat_len < PAT_CAP) begin
					pat_bytes[pat_len] = data;
					pat_len++;
				end else begin
					ovf = 1'b1;
				end
				return;
			end
			if (first) begin
				hits = '0;
				win_fill = 0;
			end
			for (int i = 0; i < PAT_CAP - 1; i++) win_bytes[i] = win_bytes[i + 1];
			win_bytes[PAT_CAP - 1] = data;
			if (win_fill < PAT_CAP) win_fill++;
			hit = window_hit();
			if (hit && hits != 32'hFFFF_FFFF) hits++;
			res.match_end = hit;
			res.match_count = hits;
			res.final_res = last;
			res.pattern_overflow = ovf;
			due.push_back(res);
		endfunction

		function void check_result(logic me, logic [31:0] cnt, logic fin, logic pov);
			text_result_t exp;
			if (due.size() == 0) begin
				$error("unexpected result word: match_end %0d count %0d", me, cnt);
				errors++;
				return;
			end
			exp = due.pop_front();
			if (me !== exp.match_end) begin
				$error("match_end: expected %0d, got %0d", exp.match_end, me);
				errors++;
			end
			if (cnt !== exp.match_count) begin
				$error("match_count: expected %0d, got %0d", exp.match_count, cnt);
				errors++;
			end
			if (fin !== exp.final_res) begin
				$error("final_res: expected %0d, got %0d", exp.final_res, fin);
				errors++;
			end
			if (pov !== exp.pattern_overflow) begin
				$error("pattern_overflow: expected %0d, got %0d", exp.pattern_overflow, pov);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // data[7:0]
	logic [1:0]  s_axis_tuser;   // command[0], first[1]
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // match_count[31:0]
	logic [1:0]  m_axis_tuser;   // match_end[0], pattern_overflow[1]
	logic        m_axis_tlast;

	occurrence_board board;
	logic [7:0]      cur_pat[$];
	int unsigned     words_sent = 0;
	int unsigned     target = 32'hFFFF_FFFF;
	bit              idle_on = 1'b1;
	bit              hold_req = 1'b0;

	dna_qgram_pattern_count_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_dna_qgram_pattern_count_top NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tuser[0], m_axis_tdata, m_axis_tlast, m_axis_tuser[1]);
	end

	initial begin
		int unsigned stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(input bit cmd, input logic [7:0] data, input bit first,
	                         input bit last);
		if (words_sent + CALM_WORDS >= target) idle_on = 1'b0;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= {first, cmd};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		board.take_word(cmd, data, first, last);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (board.due.size() != 0);
	endtask

	task automatic load_pattern(input int unsigned len);
		logic [7:0] b;
		cur_pat.delete();
		for (int unsigned i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i < PAT_CAP) cur_pat.push_back(b);
			send_word(CMD_PATTERN, b, i == 0, 1'($urandom_range(0, 1)));
		end
	endtask

	// plant occurrences at random, the last possibly cut short, some with one spoiled byte
	task automatic send_text(input int unsigned len, input bit fresh, input bit closes);
		int unsigned m;
		int unsigned r;
		int unsigned j;
		int unsigned spoil;
		bit          planting;
		logic [7:0]  b;
		m = cur_pat.size();
		r = m % GRAM_SIZE;
		j = 0;
		spoil = 0;
		planting = 1'b0;
		for (int unsigned pos = 0; pos < len; pos++) begin
			if (!planting && m != 0 && $urandom_range(0, 2) == 0) begin
				planting = 1'b1;
				j = 0;
				spoil = ($urandom_range(0, 4) == 0) ? $urandom_range(0, m - 1) : m;
			end
			b = 8'($urandom_range(0, 255));
			if (planting) begin
				if (j < r) b = cur_pat[j];
				else b = (b & ~FP_MASK) | (cur_pat[j] & FP_MASK);
				if (j == spoil) b = b ^ 8'h02;
				j++;
				if (j == m) planting = 1'b0;
			end
			send_word(CMD_TEXT, b, fresh && pos == 0, closes && pos == len - 1);
		end
	endtask

	initial begin
		int unsigned round;
		int unsigned plen;
		int unsigned tlen;
		int unsigned sel;
		board = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pattern
		send_word(CMD_TEXT, 8'h00, 1'b1, 1'b0);
		send_word(CMD_TEXT, 8'hFF, 1'b0, 1'b1);
		// short pattern compares exactly
		send_word(CMD_PATTERN, 8'hA5, 1'b1, 1'b0);
		send_word(CMD_PATTERN, 8'h5A, 1'b0, 1'b0);
		send_word(CMD_TEXT, 8'hA5, 1'b1, 1'b0);
		send_word(CMD_TEXT, 8'h5A, 1'b0, 1'b0);
		send_word(CMD_TEXT, 8'hA5, 1'b0, 1'b0);
		send_word(CMD_TEXT, 8'h5B, 1'b0, 1'b1);
		// one exact head byte, rest by fingerprint
		send_word(CMD_PATTERN, 8'h12, 1'b1, 1'b0);
		send_word(CMD_PATTERN, 8'h06, 1'b0, 1'b0);
		send_word(CMD_PATTERN, 8'h00, 1'b0, 1'b0);
		send_word(CMD_PATTERN, 8'hFF, 1'b0, 1'b0);
		send_word(CMD_PATTERN, 8'h80, 1'b0, 1'b1);
		send_word(CMD_TEXT, 8'h12, 1'b1, 1'b0);
		send_word(CMD_TEXT, 8'hF6, 1'b0, 1'b0);
		send_word(CMD_TEXT, 8'hF9, 1'b0, 1'b0);
		send_word(CMD_TEXT, 8'h7F, 1'b0, 1'b0);
		send_word(CMD_TEXT, 8'h01, 1'b0, 1'b0);
		send_word(CMD_TEXT, 8'h13, 1'b0, 1'b1);

		target = words_sent + RANDOM_WORDS;
		round = 0;
		while (words_sent < target) begin
			idle_on = (words_sent + CALM_WORDS < target) && ($urandom_range(0, 3) != 0);
			if (round == 2) hold_req = 1'b1;
			if (round == 5) drain_results();
			case ($urandom_range(0, 9))
				0:       plen = $urandom_range(13, PAT_CAP - 1);
				1:       plen = $urandom_range(PAT_CAP, PAT_CAP + 8);
				default: plen = $urandom_range(1, 12);
			endcase
			if (round == 0) plen = PAT_CAP;
			if (round == 1) plen = PAT_CAP + 6;
			tlen = (plen > 12) ? $urandom_range(plen, 2 * plen + 20) : $urandom_range(4, 40);
			sel = (round < 3) ? 3 : $urandom_range(0, 9);
			case (sel)
				0: begin
					repeat ($urandom_range(1, 6))
						send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
				1: begin
					load_pattern(plen);
					send_text(tlen, 1'b0, 1'($urandom_range(0, 1)));
				end
				2: begin
					load_pattern(plen);
					send_text(tlen, 1'b1, 1'b1);
					send_text($urandom_range(1, 20), 1'b0, 1'b1);
				end
				default: begin
					load_pattern(plen);
					send_text(tlen, 1'b1, 1'b1);
				end
			endcase
			round++;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0 && board.due.size() == 0)
			$display("tb_dna_qgram_pattern_count_top OK");
		else
			$display("tb_dna_qgram_pattern_count_top NOT OK");
		$finish;
	end

endmodule
